@@ rtl/core/wfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfa_pkg
// Shared types and constants of the worst-fit allocator: section records,
// the search wave that runs along the cell chain, and the cell operations.
// ----------------------------------------------------------------------------
package wfa_pkg;

    localparam int unsigned VAL_W = 31;

    localparam logic [VAL_W-1:0] RESET_MEM_SIZE = 31'd1024;
    localparam logic [VAL_W-1:0] FIRST_CELL     = 31'd1;
    localparam logic [VAL_W-1:0] FIRST_ID       = 31'd1;
    localparam logic [VAL_W-1:0] LAST_ID        = 31'h7FFF_FFFF;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_INIT    = 3'd1;
    localparam logic [2:0] OP_TAKE    = 3'd2;
    localparam logic [2:0] OP_SPLIT   = 3'd3;
    localparam logic [2:0] OP_RELEASE = 3'd4;
    localparam logic [2:0] OP_MERGE   = 3'd5;

    typedef struct packed {
        logic             valid;
        logic             free;
        logic [VAL_W-1:0] start;
        logic [VAL_W-1:0] len;
        logic [VAL_W-1:0] owner;
    } wfa_sect_t;

    typedef struct packed {
        logic             valid;
        logic             found;
        logic [VAL_W-1:0] len;
        logic [VAL_W-1:0] start;
        logic             prev_free;
        logic             next_free;
    } wfa_wave_t;

    typedef struct packed {
        logic [2:0]       op;
        logic             is_free;
        logic [VAL_W-1:0] size;
        logic [VAL_W-1:0] id;
        logic [VAL_W-1:0] target;
        logic [VAL_W-1:0] init_len;
    } wfa_ctl_t;

endpackage

@@ rtl/core/wfa_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfa_cell
// One entry of the section table. It holds one section, updates it from the
// broadcast operation and its two neighbors, and passes the search wave on.
// ----------------------------------------------------------------------------
module wfa_cell
    import wfa_pkg::*;
#(
    parameter int IW    = 6,
    parameter int INDEX = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  wfa_ctl_t      ctl,
    input  logic [IW-1:0] pos,
    input  wfa_sect_t     prev_sect,
    input  wfa_sect_t     next_sect,
    output wfa_sect_t     sect,
    input  wfa_wave_t     wave_in,
    input  logic [IW-1:0] idx_in,
    output wfa_wave_t     wave_out,
    output logic [IW-1:0] idx_out
);

    localparam logic [IW:0] MY = (IW+1)'(INDEX);

    localparam wfa_sect_t HEAD_SECT = '{valid: 1'b1, free: 1'b1, start: FIRST_CELL,
                                        len: RESET_MEM_SIZE, owner: '0};
    localparam wfa_sect_t RESET_SECT = (INDEX == 0) ? HEAD_SECT : wfa_sect_t'('0);

    wfa_sect_t     sect_reg;
    wfa_sect_t     sect_next;
    wfa_wave_t     wave_reg;
    wfa_wave_t     wave_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic [IW:0]   pos_x;
    logic          at_pos;
    logic          above_pos;
    logic          just_above;

    assign pos_x      = {1'b0, pos};
    assign at_pos     = (MY == pos_x);
    assign above_pos  = (MY > pos_x);
    assign just_above = (MY == pos_x + 1'b1);

    always_comb
    begin
        sect_next = sect_reg;
        case (ctl.op)
            OP_INIT:
            begin
                sect_next = '0;
                if (INDEX == 0)
                begin
                    sect_next.valid = 1'b1;
                    sect_next.free  = 1'b1;
                    sect_next.start = FIRST_CELL;
                    sect_next.len   = ctl.init_len;
                end
            end
            OP_TAKE:
            begin
                if (at_pos)
                begin
                    sect_next.free  = 1'b0;
                    sect_next.owner = ctl.id;
                end
            end
            OP_SPLIT:
            begin
                if (at_pos)
                begin
                    sect_next.len   = ctl.size;
                    sect_next.free  = 1'b0;
                    sect_next.owner = ctl.id;
                end
                else if (just_above)
                begin
                    sect_next.valid = 1'b1;
                    sect_next.free  = 1'b1;
                    sect_next.start = prev_sect.start + ctl.size;
                    sect_next.len   = prev_sect.len - ctl.size;
                    sect_next.owner = '0;
                end
                else if (above_pos)
                begin
                    sect_next = prev_sect;
                end
            end
            OP_RELEASE:
            begin
                if (at_pos)
                begin
                    sect_next.free  = 1'b1;
                    sect_next.owner = '0;
                end
            end
            OP_MERGE:
            begin
                if (at_pos)
                begin
                    sect_next.len   = sect_reg.len + next_sect.len;
                    sect_next.free  = 1'b1;
                    sect_next.owner = '0;
                end
                else if (above_pos)
                begin
                    sect_next = next_sect;
                end
            end
            default:
            begin
                sect_next = sect_reg;
            end
        endcase
    end

    always_comb
    begin
        wave_next = wave_in;
        idx_next  = idx_in;
        if (wave_in.valid && sect_reg.valid)
        begin
            if (!ctl.is_free)
            begin
                if (sect_reg.free && (!wave_in.found || sect_reg.len > wave_in.len))
                begin
                    wave_next.found = 1'b1;
                    wave_next.len   = sect_reg.len;
                    wave_next.start = sect_reg.start;
                    idx_next        = IW'(INDEX);
                end
            end
            else if (!wave_in.found && !sect_reg.free && sect_reg.owner == ctl.target)
            begin
                wave_next.found     = 1'b1;
                wave_next.prev_free = prev_sect.valid && prev_sect.free;
                wave_next.next_free = next_sect.valid && next_sect.free;
                idx_next            = IW'(INDEX);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sect_reg <= RESET_SECT;
            wave_reg <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            sect_reg <= sect_next;
            wave_reg <= wave_next;
            idx_reg  <= idx_next;
        end
    end

    assign sect     = sect_reg;
    assign wave_out = wave_reg;
    assign idx_out  = idx_reg;

endmodule

@@ rtl/core/worst_fit_allocator_with_coalescing_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worst_fit_allocator_with_coalescing_top
// Worst-fit allocator over a table of sections held in a chain of cells.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_stall  | cmd, alloc_size, free_target
//  out      | out_valid / out_stall| granted, start_index
//  config   | cfg_wr_en            | cfg_wr_data (memory size)
//
// Each request runs S_LAUNCH, S_SCAN, S_APPLY1 and S_APPLY2, and an allocate
// result then waits in S_OUT: a search wave walks the cell chain one cell per
// cycle, then S_APPLY1 and S_APPLY2 update the table. Reset or a config write
// leaves one free section. A stalled result holds in the output register while
// the next request is already taken.
// ----------------------------------------------------------------------------
module worst_fit_allocator_with_coalescing_top
    import wfa_pkg::*;
#(
    parameter int MAX_SECTIONS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [30:0] alloc_size,
    input  logic [30:0] free_target,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        granted,
    output logic [30:0] start_index,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data
);

    localparam int IW = $clog2(MAX_SECTIONS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LAUNCH = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_APPLY1 = 3'd3;
    localparam logic [2:0] S_APPLY2 = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic          cmd_reg;
    logic [30:0]   size_reg, target_reg, id_reg, counter_reg, counter_next;
    logic [2:0]    op1_reg, op1_next, op2_reg, op2_next;
    logic [IW-1:0] pos1_reg, pos1_next, pos2_reg, pos2_next;
    logic          grant_reg, grant_next;
    logic [30:0]   gstart_reg, gstart_next;
    logic          out_valid_reg;
    logic          granted_reg;
    logic [30:0]   start_index_reg;
    logic          accept;
    logic          load_out;
    logic          ok;
    logic          exact;

    wfa_ctl_t      ctl;
    logic [IW-1:0] pos;
    wfa_sect_t     sect [MAX_SECTIONS];
    wfa_wave_t     wave [MAX_SECTIONS];
    logic [IW-1:0] idx  [MAX_SECTIONS];
    wfa_wave_t     wave_first;
    wfa_wave_t     w_last;
    logic [IW-1:0] idx_last;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        wave_first       = '0;
        wave_first.valid = (state_reg == S_LAUNCH);
    end

    always_comb
    begin
        ctl.is_free  = cmd_reg;
        ctl.size     = size_reg;
        ctl.id       = id_reg;
        ctl.target   = target_reg;
        ctl.init_len = cfg_wr_data;
        if (cfg_wr_en)
        begin
            ctl.op = OP_INIT;
        end
        else if (state_reg == S_APPLY1)
        begin
            ctl.op = op1_reg;
        end
        else if (state_reg == S_APPLY2)
        begin
            ctl.op = op2_reg;
        end
        else
        begin
            ctl.op = OP_NONE;
        end
    end

    assign pos = (state_reg == S_APPLY2) ? pos2_reg : pos1_reg;

    genvar g;
    generate
        for (g = 0; g < MAX_SECTIONS; g++)
        begin : g_cell
            wfa_sect_t     prev_s;
            wfa_sect_t     next_s;
            wfa_wave_t     w_in;
            logic [IW-1:0] i_in;

            if (g == 0)
            begin : g_head
                assign prev_s = '0;
                assign w_in   = wave_first;
                assign i_in   = '0;
            end
            else
            begin : g_body
                assign prev_s = sect[g-1];
                assign w_in   = wave[g-1];
                assign i_in   = idx[g-1];
            end

            if (g == MAX_SECTIONS - 1)
            begin : g_tail
                assign next_s = '0;
            end
            else
            begin : g_inner
                assign next_s = sect[g+1];
            end

            wfa_cell #(
                .IW    (IW),
                .INDEX (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .pos       (pos),
                .prev_sect (prev_s),
                .next_sect (next_s),
                .sect      (sect[g]),
                .wave_in   (w_in),
                .idx_in    (i_in),
                .wave_out  (wave[g]),
                .idx_out   (idx[g])
            );
        end
    endgenerate

    assign w_last   = wave[MAX_SECTIONS-1];
    assign idx_last = idx[MAX_SECTIONS-1];
    assign exact    = (w_last.len == size_reg);
    assign ok       = w_last.found && (size_reg != '0) && (w_last.len >= size_reg)
                      && (exact || !sect[MAX_SECTIONS-1].valid);

    always_comb
    begin
        state_next   = state_reg;
        counter_next = counter_reg;
        op1_next     = op1_reg;
        op2_next     = op2_reg;
        pos1_next    = pos1_reg;
        pos2_next    = pos2_reg;
        grant_next   = grant_reg;
        gstart_next  = gstart_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next   = S_LAUNCH;
                    counter_next = (counter_reg == LAST_ID) ? FIRST_ID
                                                            : counter_reg + 1'b1;
                end
            end
            S_LAUNCH:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (w_last.valid)
                begin
                    state_next = S_APPLY1;
                    pos1_next  = idx_last;
                    pos2_next  = idx_last - 1'b1;
                    op2_next   = OP_NONE;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        op1_next    = ok ? (exact ? OP_TAKE : OP_SPLIT) : OP_NONE;
                        grant_next  = ok;
                        gstart_next = ok ? w_last.start : '0;
                    end
                    else
                    begin
                        op1_next = !w_last.found ? OP_NONE :
                                   (w_last.next_free ? OP_MERGE : OP_RELEASE);
                        op2_next = (w_last.found && w_last.prev_free) ? OP_MERGE
                                                                      : OP_NONE;
                    end
                end
            end
            S_APPLY1:
            begin
                state_next = S_APPLY2;
            end
            S_APPLY2:
            begin
                state_next = (cmd_reg == CMD_FREE) ? S_IDLE : S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_wr_en)
        begin
            counter_next = FIRST_ID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            counter_reg   <= FIRST_ID;
            out_valid_reg <= 1'b0;
            op1_reg       <= OP_NONE;
            op2_reg       <= OP_NONE;
        end
        else
        begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
            op1_reg     <= op1_next;
            op2_reg     <= op2_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            size_reg   <= alloc_size;
            target_reg <= free_target;
            id_reg     <= counter_reg;
        end
        pos1_reg   <= pos1_next;
        pos2_reg   <= pos2_next;
        grant_reg  <= grant_next;
        gstart_reg <= gstart_next;
        if (load_out)
        begin
            granted_reg     <= grant_reg;
            start_index_reg <= gstart_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign granted     = granted_reg;
    assign start_index = start_index_reg;

endmodule
